>>> hw/rtl/sum_of_pairs_column_score_defines.svh
// Assertion macros shared by the sum-of-pairs column scorer.
`ifndef SUM_OF_PAIRS_COLUMN_SCORE_DEFINES_SVH
`define SUM_OF_PAIRS_COLUMN_SCORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every rising clock edge outside reset.
`define SOPCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check on every rising clock edge, reset included.
`define SOPCS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SOPCS_ASSERT(label, prop, msg)
`define SOPCS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> hw/rtl/sopcs_pkg.sv
// Shared widths, codes and types of the sum-of-pairs column scorer.
package sopcs_pkg;

   localparam int SYM_W       = 3;
   localparam int ENTRY_W     = 16;
   localparam int COL_COST_W  = 21;
   localparam int TOTAL_W     = 32;
   localparam int ROWS_CNT_W  = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SCORE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAP_COST    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'd1;

   // Control that travels with one item down the pipeline.
   typedef struct packed {
      logic valid;
      logic score;
      logic bad;
      logic last;
   } sopcs_ctl_type;

endpackage

>>> hw/rtl/sum_of_pairs_column_score.sv
// Top level of the sum-of-pairs column scorer.
//
// Sum-of-pairs scoring of a multiple alignment, one aligned column per item.
// Load the (ALPHABET+1)x(ALPHABET+1) substitution table first with write items
// (op = 0); the code ALPHABET is the gap symbol, so the table carries a gap row
// and a gap column. A score item (op = 1) holds one symbol code per row, row 0
// in the lowest three bits. For every pair of active rows the block adds the
// table entry and gap_cost once per gap in the pair, then adds that column
// cost to a 32-bit running total that saturates at the signed limits. The
// column marked last reports done_res with the final total and clears the
// total for the next alignment. A column with a code above ALPHABET in an
// active row reports bad_symbol, costs zero and leaves the total alone. Every
// item gives exactly one result, write items included. Throughput is one item
// per clock unless a result is stalled: the input register, a table read stage,
// a column adder stage and the result register form a four-register pipeline.
// The table is replicated once per row pair so that all pair lookups happen in
// the same read cycle; the whole pipeline holds while a finished result is
// stalled. Table entries are not cleared at reset, so write every entry a
// column can reach before scoring.
// Change gap_cost and rows_in_use only while no items are in flight.
`include "sum_of_pairs_column_score_defines.svh"

module sum_of_pairs_column_score #(
   parameter int ROWS     = 4,
   parameter int ALPHABET = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Item channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_op,
   input  logic [ROWS*sopcs_pkg::SYM_W-1:0]         req_column,
   input  logic [sopcs_pkg::SYM_W-1:0]              req_row_symbol,
   input  logic [sopcs_pkg::SYM_W-1:0]              req_col_symbol,
   input  logic signed [sopcs_pkg::ENTRY_W-1:0]     req_entry_value,
   input  logic                                     req_last_column,
   // Result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [sopcs_pkg::COL_COST_W-1:0]  rsp_column_cost,
   output logic signed [sopcs_pkg::TOTAL_W-1:0]     rsp_total_cost,
   output logic                                     rsp_done_res,
   output logic                                     rsp_bad_symbol,
   // Register write channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [sopcs_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sopcs_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import sopcs_pkg::*;

   localparam int SYMS   = ALPHABET + 1;
   localparam int DEPTH  = SYMS * SYMS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NPAIRS = ROWS * (ROWS - 1) / 2;
   localparam int K_W    = $clog2(2 * NPAIRS + 1);
   localparam int GT_W   = ENTRY_W + K_W + 1;

   // Configuration registers
   logic signed [ENTRY_W-1:0]     gap_cost_ff;
   logic [ROWS_CNT_W-1:0]         rows_in_use_ff;

   // Input register
   logic                          s1_valid_ff;
   logic                          s1_op_ff;
   logic [ROWS*SYM_W-1:0]         s1_column_ff;
   logic [SYM_W-1:0]              s1_row_symbol_ff;
   logic [SYM_W-1:0]              s1_col_symbol_ff;
   logic signed [ENTRY_W-1:0]     s1_entry_value_ff;
   logic                          s1_last_column_ff;

   logic                          advance;
   logic [NPAIRS-1:0][ADDR_W-1:0] rd_addr;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [ENTRY_W-1:0]            wr_data;
   sopcs_ctl_type                 s2_ctl;
   logic [NPAIRS-1:0]             s2_pair_active;
   logic signed [GT_W-1:0]        s2_gap_term;
   logic [NPAIRS-1:0][ENTRY_W-1:0] s2_rd_data;

   // The whole pipeline moves together; hold it only while a finished result
   // sits in the result register and the receiver stalls it.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Always ready; software must write only while the block is idle (unchecked).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_cost_ff    <= '0;
         rows_in_use_ff <= ROWS_CNT_W'(4);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GAP_COST:    gap_cost_ff    <= csr_wdata[ENTRY_W-1:0];
            CSR_ROWS_IN_USE: rows_in_use_ff <= csr_wdata[ROWS_CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the next item on each advance; an empty slot just carries valid low.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff          <= req_op;
         s1_column_ff      <= req_column;
         s1_row_symbol_ff  <= req_row_symbol;
         s1_col_symbol_ff  <= req_col_symbol;
         s1_entry_value_ff <= req_entry_value;
         s1_last_column_ff <= req_last_column;
      end
   end

   // Split the column into symbols, form pair addresses and the gap term.
   sopcs_decode #(
      .ROWS     (ROWS),
      .ALPHABET (ALPHABET)
   ) u_decode (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .s1_valid       (s1_valid_ff),
      .s1_op          (s1_op_ff),
      .s1_column      (s1_column_ff),
      .s1_row_symbol  (s1_row_symbol_ff),
      .s1_col_symbol  (s1_col_symbol_ff),
      .s1_entry_value (s1_entry_value_ff),
      .s1_last_column (s1_last_column_ff),
      .gap_cost       (gap_cost_ff),
      .rows_in_use    (rows_in_use_ff),
      .rd_addr        (rd_addr),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .ctl            (s2_ctl),
      .pair_active    (s2_pair_active),
      .gap_term       (s2_gap_term)
   );

   // A write in the input register lands at the same edge the following item
   // enters, so that item already reads the new entry.
   sopcs_table #(
      .NPORTS (NPAIRS),
      .DEPTH  (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (s2_rd_data)
   );

   // Sum the column, update the running total, and present the result.
   sopcs_accum #(
      .NPAIRS (NPAIRS),
      .GT_W   (GT_W)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .ctl             (s2_ctl),
      .pair_active     (s2_pair_active),
      .rd_data         (s2_rd_data),
      .gap_term        (s2_gap_term),
      .rsp_valid       (rsp_valid),
      .rsp_column_cost (rsp_column_cost),
      .rsp_total_cost  (rsp_total_cost),
      .rsp_done_res    (rsp_done_res),
      .rsp_bad_symbol  (rsp_bad_symbol)
   );

   // A flagged column never contributes cost.
   `SOPCS_ASSERT(a_bad_costs_zero, rsp_valid && rsp_bad_symbol |-> rsp_column_cost == '0, "bad column carries nonzero cost")
   // Input is never stalled while the result register is empty.
   `SOPCS_ASSERT(a_no_idle_stall, !rsp_valid |-> !req_stall, "input stalled with empty result register")
   // Reset leaves no result pending.
   `SOPCS_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")

endmodule

>>> hw/rtl/sopcs_decode.sv
// Column decode: symbol split, pair addresses, gap term and table write port.
module sopcs_decode #(
   parameter int ROWS     = 4,
   parameter int ALPHABET = 4,
   localparam int SYMS    = ALPHABET + 1,
   localparam int DEPTH   = SYMS * SYMS,
   localparam int ADDR_W  = $clog2(DEPTH),
   localparam int NPAIRS  = ROWS * (ROWS - 1) / 2,
   localparam int K_W     = $clog2(2 * NPAIRS + 1),
   localparam int GT_W    = sopcs_pkg::ENTRY_W + K_W + 1
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      advance,
   input  logic                                      s1_valid,
   input  logic                                      s1_op,
   input  logic [ROWS*sopcs_pkg::SYM_W-1:0]          s1_column,
   input  logic [sopcs_pkg::SYM_W-1:0]               s1_row_symbol,
   input  logic [sopcs_pkg::SYM_W-1:0]               s1_col_symbol,
   input  logic signed [sopcs_pkg::ENTRY_W-1:0]      s1_entry_value,
   input  logic                                      s1_last_column,
   input  logic signed [sopcs_pkg::ENTRY_W-1:0]      gap_cost,
   input  logic [sopcs_pkg::ROWS_CNT_W-1:0]          rows_in_use,
   output logic [NPAIRS-1:0][ADDR_W-1:0]             rd_addr,
   output logic                                      wr_en,
   output logic [ADDR_W-1:0]                         wr_addr,
   output logic [sopcs_pkg::ENTRY_W-1:0]             wr_data,
   output sopcs_pkg::sopcs_ctl_type                  ctl,
   output logic [NPAIRS-1:0]                         pair_active,
   output logic signed [GT_W-1:0]                    gap_term
);
   import sopcs_pkg::*;

   localparam logic [SYM_W-1:0]      GAP_CODE = SYM_W'(ALPHABET);
   localparam logic [ROWS_CNT_W-1:0] N_MAX    = ROWS_CNT_W'(ROWS);
   localparam logic [ROWS_CNT_W-1:0] N_MIN    = ROWS_CNT_W'(2);
   localparam logic [ADDR_W-1:0]     SYMS_A   = ADDR_W'(SYMS);

   logic [ROWS_CNT_W-1:0]     n_rows;
   logic [ROWS-1:0][SYM_W-1:0] sym;
   logic [ROWS-1:0]           row_active;
   logic [ROWS-1:0]           row_bad;
   logic [ROWS-1:0]           row_gap;
   logic [NPAIRS-1:0][1:0]    pair_gaps;
   logic [NPAIRS-1:0]         pair_active_in;
   logic [K_W-1:0]            gap_count;
   logic signed [GT_W-1:0]    gap_term_in;
   sopcs_ctl_type             ctl_in;
   sopcs_ctl_type             ctl_ff;
   logic [NPAIRS-1:0]         pair_active_ff;
   logic signed [GT_W-1:0]    gap_term_ff;

   // Clamp the active row count into the supported range.
   always_comb begin
      if (rows_in_use < N_MIN) begin
         n_rows = N_MIN;
      end else if (rows_in_use > N_MAX) begin
         n_rows = N_MAX;
      end else begin
         n_rows = rows_in_use;
      end
   end

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      assign sym[r]        = s1_column[r*SYM_W +: SYM_W];
      assign row_active[r] = (ROWS_CNT_W'(r) < n_rows);
      assign row_bad[r]    = row_active[r] && (sym[r] > GAP_CODE);
      assign row_gap[r]    = row_active[r] && (sym[r] == GAP_CODE);
   end

   for (genvar i = 0; i < ROWS; i++) begin : g_pi
      for (genvar j = i + 1; j < ROWS; j++) begin : g_pj
         localparam int P = i * ROWS - (i * (i + 1)) / 2 + (j - i - 1);
         assign pair_active_in[P] = row_active[j];
         assign pair_gaps[P] = {1'b0, row_gap[i] & row_active[j]} + {1'b0, row_gap[j]};
         // Out-of-range codes occur only in masked pairs or bad columns, whose cost is zeroed; park them on entry zero.
         assign rd_addr[P] = ((sym[i] <= GAP_CODE) && (sym[j] <= GAP_CODE)) ?
                             ADDR_W'(sym[i]) * SYMS_A + ADDR_W'(sym[j]) : '0;
      end
   end

   always_comb begin
      gap_count = '0;
      for (int p = 0; p < NPAIRS; p++) begin
         gap_count = gap_count + K_W'(pair_gaps[p]);
      end
   end

   assign gap_term_in = GT_W'($signed(gap_cost)) * GT_W'($signed({1'b0, gap_count}));

   assign ctl_in.valid = s1_valid;
   assign ctl_in.score = (s1_op == OP_SCORE);
   assign ctl_in.bad   = (s1_op == OP_SCORE) && (|row_bad);
   assign ctl_in.last  = (s1_op == OP_SCORE) && s1_last_column;

   // Table write; drop writes whose indices fall outside the table.
   assign wr_en   = advance && s1_valid && (s1_op == OP_WRITE) &&
                    (s1_row_symbol <= GAP_CODE) && (s1_col_symbol <= GAP_CODE);
   assign wr_addr = ADDR_W'(s1_row_symbol) * SYMS_A + ADDR_W'(s1_col_symbol);
   assign wr_data = s1_entry_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_active_ff <= pair_active_in;
         gap_term_ff    <= gap_term_in;
      end
   end

   assign ctl         = ctl_ff;
   assign pair_active = pair_active_ff;
   assign gap_term    = gap_term_ff;

endmodule

>>> hw/rtl/sopcs_table.sv
// Substitution table, one copy per row pair so every pair reads in the same cycle.
module sopcs_table #(
   parameter int NPORTS = 6,
   parameter int DEPTH  = 25,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [ADDR_W-1:0]                        wr_addr,
   input  logic [sopcs_pkg::ENTRY_W-1:0]            wr_data,
   input  logic                                     rd_en,
   input  logic [NPORTS-1:0][ADDR_W-1:0]            rd_addr,
   output logic [NPORTS-1:0][sopcs_pkg::ENTRY_W-1:0] rd_data
);
   import sopcs_pkg::*;

   for (genvar p = 0; p < NPORTS; p++) begin : g_lane
      logic [ENTRY_W-1:0] cost_mem_ff [DEPTH];
      logic [ENTRY_W-1:0] lane_data_ff;

      always_ff @(posedge clock) begin
         if (wr_en) begin
            cost_mem_ff[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            lane_data_ff <= cost_mem_ff[rd_addr[p]];
         end
      end

      assign rd_data[p] = lane_data_ff;
   end

endmodule

>>> hw/rtl/sopcs_accum.sv
// Column sum, saturating running total and result register.
module sopcs_accum #(
   parameter int NPAIRS = 6,
   parameter int GT_W   = 21
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       advance,
   input  sopcs_pkg::sopcs_ctl_type                   ctl,
   input  logic [NPAIRS-1:0]                          pair_active,
   input  logic [NPAIRS-1:0][sopcs_pkg::ENTRY_W-1:0]  rd_data,
   input  logic signed [GT_W-1:0]                     gap_term,
   output logic                                       rsp_valid,
   output logic signed [sopcs_pkg::COL_COST_W-1:0]    rsp_column_cost,
   output logic signed [sopcs_pkg::TOTAL_W-1:0]       rsp_total_cost,
   output logic                                       rsp_done_res,
   output logic                                       rsp_bad_symbol
);
   import sopcs_pkg::*;

   localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
   localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

   logic signed [COL_COST_W-1:0] col_sum;
   sopcs_ctl_type                ctl3_ff;
   logic signed [COL_COST_W-1:0] col_cost_ff;
   logic signed [TOTAL_W:0]      sum_wide;
   logic signed [TOTAL_W-1:0]    sat_total;
   logic signed [TOTAL_W-1:0]    shown_total;
   logic signed [TOTAL_W-1:0]    running_total_ff;
   logic signed [TOTAL_W-1:0]    running_total_in;
   logic                         rsp_valid_ff;
   logic signed [COL_COST_W-1:0] rsp_column_cost_ff;
   logic signed [TOTAL_W-1:0]    rsp_total_cost_ff;
   logic                         rsp_done_res_ff;
   logic                         rsp_bad_symbol_ff;

   // Add the active pair entries and the gap term; zero for writes and bad columns.
   always_comb begin
      col_sum = COL_COST_W'(gap_term);
      for (int p = 0; p < NPAIRS; p++) begin
         if (pair_active[p]) begin
            col_sum = col_sum + COL_COST_W'($signed(rd_data[p]));
         end
      end
      if (!ctl.score || ctl.bad) begin
         col_sum = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else if (advance) begin
         ctl3_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         col_cost_ff <= col_sum;
      end
   end

   assign sum_wide = {running_total_ff[TOTAL_W-1], running_total_ff} +
                     (TOTAL_W+1)'(col_cost_ff);

   always_comb begin
      if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]) begin
         sat_total = sum_wide[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
      end else begin
         sat_total = sum_wide[TOTAL_W-1:0];
      end
   end

   always_comb begin
      shown_total      = running_total_ff;
      running_total_in = running_total_ff;
      if (ctl3_ff.valid && ctl3_ff.score) begin
         if (!ctl3_ff.bad) begin
            shown_total      = sat_total;
            running_total_in = sat_total;
         end
         if (ctl3_ff.last) begin
            running_total_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         running_total_ff <= '0;
      end else if (advance) begin
         rsp_valid_ff     <= ctl3_ff.valid;
         running_total_ff <= running_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_column_cost_ff <= col_cost_ff;
         rsp_total_cost_ff  <= shown_total;
         rsp_done_res_ff    <= ctl3_ff.score && ctl3_ff.last;
         rsp_bad_symbol_ff  <= ctl3_ff.bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_cost = rsp_column_cost_ff;
   assign rsp_total_cost  = rsp_total_cost_ff;
   assign rsp_done_res    = rsp_done_res_ff;
   assign rsp_bad_symbol  = rsp_bad_symbol_ff;

endmodule
